// ===== src/projection_profile_peak_finder_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the projection profile peak finder
// Clocked assertions on clk, held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef PROJECTION_PROFILE_PEAK_FINDER_ASSERT_SVH
`define PROJECTION_PROFILE_PEAK_FINDER_ASSERT_SVH

// Condition must hold whenever the antecedent holds, same cycle
`define PPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the antecedent
`define PPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ppf_pkg.sv =====
// ----------------------------------------------------------------------------
// ppf_pkg
// Shared types and constants of the projection profile peak finder.
// ----------------------------------------------------------------------------
`default_nettype none

package ppf_pkg;

  localparam int CHAN_W       = 8;
  localparam int COUNT_W      = 11;
  localparam int PEAK_LINE_W  = 10;
  localparam int SUPPRESS_W   = 6;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'h7FF;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DARK_THRESHOLD  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SUPPRESS_BEFORE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SUPPRESS_AFTER  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CHAN_W-1:0]     DARK_THRESHOLD_RST  = 8'd200;
  localparam logic [SUPPRESS_W-1:0] SUPPRESS_BEFORE_RST = 6'd5;
  localparam logic [SUPPRESS_W-1:0] SUPPRESS_AFTER_RST  = 6'd4;

  typedef struct packed {
    logic [CHAN_W-1:0] pixel_red;
    logic [CHAN_W-1:0] pixel_green;
    logic [CHAN_W-1:0] pixel_blue;
    logic              line_end;
    logic              frame_end;
  } pixel_t;

  typedef struct packed {
    logic [PEAK_LINE_W-1:0] peak_line;
    logic [COUNT_W-1:0]     peak_count;
    logic                   last_peak;
  } peak_t;

  typedef struct packed {
    logic [CHAN_W-1:0]     dark_threshold;
    logic [SUPPRESS_W-1:0] suppress_before;
    logic [SUPPRESS_W-1:0] suppress_after;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_CLEAR
  } search_state_t;

endpackage

`default_nettype wire

// ===== src/ppf_mem.sv =====
// ----------------------------------------------------------------------------
// ppf_mem
// Line count store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppf_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry; the read data is registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/ppf_accum.sv =====
// ----------------------------------------------------------------------------
// ppf_accum
// Counts dark pixels, stores up to MAX_LINES line counts and starts the search.
// ----------------------------------------------------------------------------
`default_nettype none

module ppf_accum #(
  parameter int MAX_LINES = 1024,
  parameter int IW        = 10,
  parameter int NW        = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire ppf_pkg::pixel_t        pixel,
  input  wire ppf_pkg::cfg_t          cfg,
  output logic                        mem_we,
  output logic [IW-1:0]               mem_addr,
  output logic [ppf_pkg::COUNT_W-1:0] mem_data,
  output logic                        search_go,
  output logic [NW-1:0]               frame_lines
);

  import ppf_pkg::*;

  logic [COUNT_W-1:0] running_count;
  logic [NW-1:0]      line_number;
  logic               dark;
  logic               close_line;
  logic               store;
  logic [COUNT_W-1:0] count_inc;
  logic [NW-1:0]      lines_after;

  // Classify pixel and bump the saturating count
  always_comb begin
    dark = (pixel.pixel_red   < cfg.dark_threshold) &&
           (pixel.pixel_green < cfg.dark_threshold) &&
           (pixel.pixel_blue  < cfg.dark_threshold);
    count_inc = (dark && (running_count != COUNT_MAX)) ? running_count + 1'b1
                                                       : running_count;
    close_line  = accept && (pixel.line_end || pixel.frame_end);
    store       = close_line && (line_number < NW'(MAX_LINES));
    lines_after = store ? line_number + 1'b1 : line_number;
  end

  // Store the closed line and hand the line total to the search
  always_comb begin
    mem_we      = store;
    mem_addr    = line_number[IW-1:0];
    mem_data    = count_inc;
    search_go   = accept && pixel.frame_end && (lines_after != '0);
    frame_lines = lines_after;
  end

  // Advance count and line number; drop both at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
      line_number   <= '0;
    end else if (accept) begin
      running_count <= close_line ? '0 : count_inc;
      line_number   <= pixel.frame_end ? '0 : lines_after;
    end
  end

endmodule

`default_nettype wire

// ===== src/ppf_search.sv =====
// ----------------------------------------------------------------------------
// ppf_search
// Peak search sequencer: scans all stored lines through one compare unit,
// emits the peak and clears its window, for PEAK_COUNT rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module ppf_search #(
  parameter int PEAK_COUNT = 10,
  parameter int IW         = 10,
  parameter int NW         = 11
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   go,
  input  wire logic [NW-1:0]          frame_lines,
  input  wire ppf_pkg::cfg_t          cfg,
  output logic [IW-1:0]               rd_addr,
  input  wire logic [ppf_pkg::COUNT_W-1:0] rd_data,
  output logic                        clr_we,
  output logic [IW-1:0]               clr_addr,
  output logic                        busy,
  output logic                        done,
  output ppf_pkg::peak_t              peak
);

  import ppf_pkg::*;

  `include "projection_profile_peak_finder_assert.svh"

  localparam int RW = $clog2(PEAK_COUNT + 1);
  localparam int WW = NW + 7;

  search_state_t      state, state_next;
  logic [RW-1:0]      round;
  logic [NW-1:0]      n_lines;
  logic [NW-1:0]      issue_idx;
  logic               pend_valid;
  logic [NW-1:0]      pend_idx;
  logic [IW-1:0]      best;
  logic [COUNT_W-1:0] best_val;
  logic [IW-1:0]      clr_idx;
  logic [IW-1:0]      clr_hi;

  logic               issue_ok;
  logic               scan_last;
  logic               clear_last;
  logic               last_round;
  logic               start_scan;
  logic               take;
  logic [WW-1:0]      best_w;
  logic [WW-1:0]      before_w;
  logic [WW-1:0]      hi_raw;
  logic [WW-1:0]      top_line;
  logic [WW-1:0]      lo_w;
  logic [WW-1:0]      hi_w;

  // Scan and clear progress flags
  always_comb begin
    issue_ok   = (issue_idx < n_lines);
    scan_last  = pend_valid && (pend_idx == (n_lines - 1'b1));
    clear_last = (clr_idx == clr_hi);
    last_round = (round == RW'(PEAK_COUNT - 1));
    take       = pend_valid && (rd_data >= best_val);
  end

  // Window around the peak, clipped to the lines of the frame
  always_comb begin
    best_w   = WW'(best);
    before_w = WW'(cfg.suppress_before);
    hi_raw   = best_w + WW'(cfg.suppress_after);
    top_line = WW'(n_lines) - 1'b1;
    lo_w     = (best_w >= before_w) ? best_w - before_w : '0;
    hi_w     = (hi_raw > top_line) ? top_line : hi_raw;
  end

  // Next state and outputs
  always_comb begin
    state_next = state;
    start_scan = 1'b0;
    case (state)
      S_IDLE: begin
        if (go) begin
          state_next = S_SCAN;
          start_scan = 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        state_next = S_CLEAR;
      end
      S_CLEAR: begin
        if (clear_last) begin
          if (last_round) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_SCAN;
            start_scan = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    busy            = (state != S_IDLE);
    done            = (state == S_EMIT);
    peak.peak_line  = best_w[PEAK_LINE_W-1:0];
    peak.peak_count = best_val;
    peak.last_peak  = last_round;
    rd_addr         = issue_idx[IW-1:0];
    clr_we          = (state == S_CLEAR);
    clr_addr        = clr_idx;
  end

  // Hold state, round and read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      round      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == S_SCAN) && issue_ok && !start_scan;
      if (state == S_IDLE && go) begin
        round <= '0;
      end else if (state == S_CLEAR && clear_last) begin
        round <= round + 1'b1;
      end
    end
  end

  // Scan, compare and clear datapath
  always_ff @(posedge clk) begin
    if (state == S_IDLE && go) begin
      n_lines <= frame_lines;
    end
    if (start_scan) begin
      issue_idx <= '0;
      best      <= '0;
      best_val  <= '0;
    end else begin
      case (state)
        S_SCAN: begin
          if (issue_ok) begin
            issue_idx <= issue_idx + 1'b1;
          end
          pend_idx <= issue_idx;
          if (take) begin
            best     <= pend_idx[IW-1:0];
            best_val <= rd_data;
          end
        end
        S_EMIT: begin
          clr_idx <= lo_w[IW-1:0];
          clr_hi  <= hi_w[IW-1:0];
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  `PPF_ASSERT_NOW(a_clear_in_window, state == S_CLEAR, clr_idx <= clr_hi,
    "clear index ran past the window")
  `PPF_ASSERT_NOW(a_clear_in_frame, state == S_CLEAR, NW'(clr_hi) < n_lines,
    "clear window beyond the stored lines")
  `PPF_ASSERT_NOW(a_read_in_frame, pend_valid, pend_idx < n_lines,
    "scan read beyond the stored lines")
  `PPF_ASSERT_NEXT(a_emit_then_clear, state == S_EMIT, state == S_CLEAR,
    "peak not followed by its clear pass")

endmodule

`default_nettype wire

// ===== src/projection_profile_peak_finder.sv =====
// A pixel request with no frame end gives no result; after a frame end
//   with n stored lines busy rises the next cycle, the search reads the n
//   lines through one compare and the first peak strobes from the emit state.
// Throughput: one pixel per cycle while busy is low; each of PEAK_COUNT rounds
//   reads the n stored lines through one compare, emits the peak, then writes
//   the clipped window clear. The receiver cannot stall: one strobe per peak.
// ----------------------------------------------------------------------------
// projection_profile_peak_finder
// Dark pixel projection profile per line with iterative peak search.
// Reset (rst, synchronous) returns counters, config and sequencer to their
// defaults; the line count memory has no clearing pass and is written before use.
// ----------------------------------------------------------------------------
`default_nettype none

module projection_profile_peak_finder #(
  parameter int MAX_LINES  = 1024,
  parameter int PEAK_COUNT = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       wr_en,
  input  wire logic [ppf_pkg::CFG_INDEX_W-1:0] wr_index,
  input  wire logic [ppf_pkg::CFG_DATA_W-1:0]  wr_data,
  input  wire logic                       start,
  input  wire ppf_pkg::pixel_t            pixel,
  output logic                            busy,
  output logic                            done,
  output ppf_pkg::peak_t                  peak
);

  import ppf_pkg::*;

  localparam int IW = $clog2(MAX_LINES);
  localparam int NW = $clog2(MAX_LINES + 1);

  cfg_t               cfg;
  logic               accept;
  logic               acc_we;
  logic [IW-1:0]      acc_addr;
  logic [COUNT_W-1:0] acc_data;
  logic               search_go;
  logic [NW-1:0]      frame_lines;
  logic [IW-1:0]      rd_addr;
  logic [COUNT_W-1:0] rd_data;
  logic               clr_we;
  logic [IW-1:0]      clr_addr;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;

  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dark_threshold  <= DARK_THRESHOLD_RST;
      cfg.suppress_before <= SUPPRESS_BEFORE_RST;
      cfg.suppress_after  <= SUPPRESS_AFTER_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_DARK_THRESHOLD:  cfg.dark_threshold  <= wr_data;
        CFG_SUPPRESS_BEFORE: cfg.suppress_before <= wr_data[SUPPRESS_W-1:0];
        CFG_SUPPRESS_AFTER:  cfg.suppress_after  <= wr_data[SUPPRESS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ppf_accum #(
    .MAX_LINES (MAX_LINES),
    .IW        (IW),
    .NW        (NW)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel       (pixel),
    .cfg         (cfg),
    .mem_we      (acc_we),
    .mem_addr    (acc_addr),
    .mem_data    (acc_data),
    .search_go   (search_go),
    .frame_lines (frame_lines)
  );

  // Share the write port: pixels while idle, clear writes while searching
  always_comb begin
    if (busy) begin
      mem_we    = clr_we;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = acc_we;
      mem_waddr = acc_addr;
      mem_wdata = acc_data;
    end
  end

  ppf_mem #(
    .DEPTH (MAX_LINES),
    .AW    (IW),
    .DW    (COUNT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  ppf_search #(
    .PEAK_COUNT (PEAK_COUNT),
    .IW         (IW),
    .NW         (NW)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .go          (search_go),
    .frame_lines (frame_lines),
    .cfg         (cfg),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .clr_we      (clr_we),
    .clr_addr    (clr_addr),
    .busy        (busy),
    .done        (done),
    .peak        (peak)
  );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the projection profile peak finder. A pixel
// request queue feeds a clocked driver with random gaps. An in-bench model
// of the dark-pixel line profile and the peak search predicts every peak.
// A monitor compares each strobed peak, field by field, with the oldest
// prediction. Phases change the configuration between frames. They cover
// the threshold edges, ties, clipped windows, a saturating line, a frame
// with too many lines, and random frames.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  import ppf_pkg::*;

  localparam int LINES_MAX     = 1024;
  localparam int ROUNDS        = 10;
  localparam int RANDOM_PIXELS = 200;
  localparam int SETTLE        = 200;
  localparam int DRAIN_LIMIT   = 60000;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PRINT_LIMIT   = 50;

  // Index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0]  wr_data = '0;
  logic                   start = 1'b0;
  pixel_t                 pixel = '0;
  logic                   busy;
  logic                   done;
  peak_t                  peak;

  // Pixel requests waiting for the driver, peaks waiting for the monitor
  pixel_t pending[$];
  peak_t  peaks_due[$];

  // Model state and configuration
  logic [COUNT_W-1:0]    line_cnt [0:LINES_MAX-1];
  logic [COUNT_W-1:0]    run_cnt;
  int unsigned           lines_stored;
  logic [CHAN_W-1:0]     thr;
  logic [SUPPRESS_W-1:0] sup_before;
  logic [SUPPRESS_W-1:0] sup_after;

  int  gap_left = 0;
  bit  no_gaps = 1'b0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  pixels_sent = 0;
  int  frames_sent = 0;
  int  peaks_seen = 0;
  int  reg_writes = 0;
  int  random_pixels = 0;

  projection_profile_peak_finder #(
    .MAX_LINES (LINES_MAX),
    .PEAK_COUNT(ROUNDS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .start   (start),
    .pixel   (pixel),
    .busy    (busy),
    .done    (done),
    .peak    (peak)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic flag_mismatch(input string what);
    if (error_count < PRINT_LIMIT) begin
      $display("MISMATCH @ cycle %0d: %s", cycle_count, what);
    end
    error_count++;
  endtask

  // Advance the profile by one pixel; on frame end, queue the peaks
  task automatic profile_step(input pixel_t p);
    int unsigned best;
    int unsigned best_val;
    int unsigned lo;
    int unsigned hi;
    peak_t       pk;
    if (p.pixel_red < thr && p.pixel_green < thr && p.pixel_blue < thr) begin
      if (run_cnt < COUNT_MAX) begin
        run_cnt = run_cnt + 1'b1;
      end
    end
    if (p.line_end || p.frame_end) begin
      if (lines_stored < LINES_MAX) begin
        line_cnt[lines_stored] = run_cnt;
        lines_stored++;
      end
      run_cnt = '0;
    end
    if (p.frame_end) begin
      if (lines_stored != 0) begin
        for (int round = 0; round < ROUNDS; round++) begin
          best = 0;
          best_val = 32'(line_cnt[0]);
          // Later line wins a tie
          for (int unsigned i = 1; i < lines_stored; i++) begin
            if (line_cnt[i] >= best_val) begin
              best_val = 32'(line_cnt[i]);
              best = i;
            end
          end
          pk.peak_line  = best[PEAK_LINE_W-1:0];
          pk.peak_count = best_val[COUNT_W-1:0];
          pk.last_peak  = (round == ROUNDS - 1);
          peaks_due.push_back(pk);
          // Clear the window, clipped to the lines of this frame
          lo = (best >= sup_before) ? best - sup_before : 0;
          hi = best + sup_after;
          if (hi > lines_stored - 1) begin
            hi = lines_stored - 1;
          end
          for (int unsigned i = lo; i <= hi; i++) begin
            line_cnt[i] = '0;
          end
        end
      end
      run_cnt = '0;
      lines_stored = 0;
      frames_sent++;
    end
  endtask

  // Track register writes and reset in the model
  always @(posedge clk) begin
    if (rst) begin
      thr = DARK_THRESHOLD_RST;
      sup_before = SUPPRESS_BEFORE_RST;
      sup_after = SUPPRESS_AFTER_RST;
      run_cnt = '0;
      lines_stored = 0;
    end else if (wr_en) begin
      case (wr_index)
        CFG_DARK_THRESHOLD:  thr = wr_data;
        CFG_SUPPRESS_BEFORE: sup_before = wr_data[SUPPRESS_W-1:0];
        CFG_SUPPRESS_AFTER:  sup_after = wr_data[SUPPRESS_W-1:0];
        default: ;
      endcase
    end
  end

  // Drive pixel requests: hold while busy, idle for the drawn gap, then issue
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        profile_step(pixel);
        pixels_sent++;
      end
      if (start && busy) begin
        // hold the request
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending.size() != 0) begin
        pixel <= pending.pop_front();
        start <= 1'b1;
        gap_left <= no_gaps ? 0 : $urandom_range(0, 10);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check each strobed peak against the oldest prediction
  always @(posedge clk) begin
    peak_t want;
    if (!rst && done) begin
      if (peaks_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected peak line %0d count %0d",
                                peak.peak_line, peak.peak_count));
      end else begin
        want = peaks_due.pop_front();
        peaks_seen++;
        if (peak.peak_line !== want.peak_line) begin
          flag_mismatch($sformatf("peak_line %0d, want %0d",
                                  peak.peak_line, want.peak_line));
        end
        if (peak.peak_count !== want.peak_count) begin
          flag_mismatch($sformatf("peak_count %0d, want %0d (line %0d)",
                                  peak.peak_count, want.peak_count, want.peak_line));
        end
        if (peak.last_peak !== want.last_peak) begin
          flag_mismatch($sformatf("last_peak %0b, want %0b",
                                  peak.last_peak, want.last_peak));
        end
      end
    end
  end

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic le, input logic fe);
    pixel_t p;
    p.pixel_red = r;
    p.pixel_green = g;
    p.pixel_blue = b;
    p.line_end = le;
    p.frame_end = fe;
    pending.push_back(p);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    reg_writes++;
  endtask

  // Wait until every request is issued and every peak is in, then settle
  task automatic wait_idle();
    int waited;
    waited = 0;
    @(negedge clk);
    while (pending.size() != 0 || start) begin
      @(negedge clk);
    end
    while (peaks_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (peaks_due.size() != 0) begin
      flag_mismatch($sformatf("%0d peaks never arrived", peaks_due.size()));
      peaks_due.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_value(input int top);
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return top[7:0];
      default: return 8'($urandom_range(0, top));
    endcase
  endfunction

  // Random pixel biased around the current threshold
  function automatic pixel_t rand_pixel();
    pixel_t p;
    int     mode;
    p = '0;
    mode = $urandom_range(0, 9);
    if (thr != 0 && mode < 4) begin
      p.pixel_red = 8'($urandom_range(0, thr - 1));
      p.pixel_green = 8'($urandom_range(0, thr - 1));
      p.pixel_blue = 8'($urandom_range(0, thr - 1));
    end else if (thr != 0 && mode < 6) begin
      // one channel right at the threshold, the rest dark
      p.pixel_red = 8'($urandom_range(0, thr - 1));
      p.pixel_green = 8'($urandom_range(0, thr - 1));
      p.pixel_blue = 8'($urandom_range(0, thr - 1));
      case ($urandom_range(0, 2))
        0:       p.pixel_red = thr;
        1:       p.pixel_green = thr;
        default: p.pixel_blue = thr;
      endcase
    end else if (mode == 6) begin
      p.pixel_red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.pixel_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.pixel_blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else begin
      p.pixel_red = 8'($urandom_range(0, 255));
      p.pixel_green = 8'($urandom_range(0, 255));
      p.pixel_blue = 8'($urandom_range(0, 255));
    end
    return p;
  endfunction

  // Queue one frame of random lines; a few stray line ends act as noise
  task automatic queue_frame(input int lines, input int max_len);
    int     len;
    pixel_t p;
    for (int l = 0; l < lines; l++) begin
      len = $urandom_range(1, max_len);
      for (int k = 0; k < len; k++) begin
        p = rand_pixel();
        if (k == len - 1) begin
          p.line_end = 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
          p.line_end = 1'b1;
        end
        if (l == lines - 1 && k == len - 1) begin
          p.frame_end = 1'b1;
          p.line_end = 1'($urandom_range(0, 1));
        end
        pending.push_back(p);
        random_pixels++;
      end
    end
  endtask

  initial begin
    pixel_t p;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Default config: threshold edges per channel, frame end closes the line
    no_gaps = 1'b0;
    queue_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    queue_pixel(8'd199, 8'd199, 8'd199, 1'b0, 1'b0);
    queue_pixel(8'd200, 8'd0, 8'd0, 1'b0, 1'b0);
    queue_pixel(8'd0, 8'd200, 8'd0, 1'b0, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd200, 1'b0, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    queue_pixel(8'd199, 8'd0, 8'd0, 1'b1, 1'b0);
    queue_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
    queue_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b0);
    queue_pixel(8'd10, 8'd20, 8'd30, 1'b0, 1'b1);
    wait_idle();

    // Top threshold, no window: equal counts, later line must win
    write_reg(CFG_DARK_THRESHOLD, 8'd255);
    write_reg(CFG_SUPPRESS_BEFORE, 8'd0);
    write_reg(CFG_SUPPRESS_AFTER, 8'd0);
    write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
    no_gaps = 1'b1;
    for (int i = 0; i < 11; i++) begin
      if (i % 2 == 0) begin
        queue_pixel(8'd254, 8'd254, 8'd254, 1'b1, 1'b0);
      end else begin
        queue_pixel(8'd255, 8'd0, 8'd0, 1'b1, 1'b0);
      end
    end
    queue_pixel(8'd254, 8'd254, 8'd254, 1'b1, 1'b1);
    wait_idle();

    // Zero threshold, widest window: all counts zero, window clipped both ways
    write_reg(CFG_DARK_THRESHOLD, 8'd0);
    write_reg(CFG_SUPPRESS_BEFORE, 8'd63);
    write_reg(CFG_SUPPRESS_AFTER, 8'd63);
    no_gaps = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p = rand_pixel();
      p.line_end = 1'b1;
      p.frame_end = (i == 2);
      pending.push_back(p);
    end
    wait_idle();

    // Long line: dark count saturates
    write_reg(CFG_DARK_THRESHOLD, 8'd1);
    write_reg(CFG_SUPPRESS_AFTER, 8'd0);
    no_gaps = 1'b1;
    for (int i = 0; i < 2050; i++) begin
      queue_pixel(8'd0, 8'd0, 8'd0, i == 2049, 1'b0);
    end
    queue_pixel(8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
    wait_idle();

    // Too many lines: lines past the line store are dropped
    write_reg(CFG_DARK_THRESHOLD, 8'd128);
    write_reg(CFG_SUPPRESS_BEFORE, 8'd0);
    write_reg(CFG_SUPPRESS_AFTER, 8'd63);
    no_gaps = 1'b0;
    for (int i = 0; i < LINES_MAX + 6; i++) begin
      p = rand_pixel();
      p.line_end = 1'b1;
      p.frame_end = (i == LINES_MAX + 5);
      pending.push_back(p);
    end
    wait_idle();

    // Random frames under random settings, extremes favored
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      write_reg(CFG_DARK_THRESHOLD, pick_value(255));
      write_reg(CFG_SUPPRESS_BEFORE, pick_value(63));
      write_reg(CFG_SUPPRESS_AFTER, pick_value(63));
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 2)) begin
        queue_frame($urandom_range(1, 16), $urandom_range(1, 6));
      end
      wait_idle();
    end

    $display("tb: %0d pixels in %0d frames, %0d peaks checked, %0d register writes",
             pixels_sent, frames_sent, peaks_seen, reg_writes);
    $display("tb: covered threshold edges, ties, clipped windows, saturation, line overflow");
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Drop the run if it hangs
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/ppf_pkg.sv
src/ppf_mem.sv
src/ppf_accum.sv
src/ppf_search.sv
src/projection_profile_peak_finder.sv
test/tb.sv
